// ----- rtl/mpfb_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mpfb_pkg
// shared types and constants for the page framebuffer text unit
// ----------------------------------------------------------------------------
package mpfb_pkg;

    localparam int SCREEN_WIDTH_DEF   = 128;
    localparam int SCREEN_HEIGHT_DEF  = 64;
    localparam int MAX_GLYPH_COLS_DEF = 16;

    localparam int GW_RESET = 7;
    localparam int GH_RESET = 10;

    localparam logic [7:0] CODE_LO = 8'd32;
    localparam logic [7:0] CODE_HI = 8'd126;

    typedef enum logic [2:0] {
        MODE_FILL   = 3'd0,
        MODE_PIXEL  = 3'd1,
        MODE_CURSOR = 3'd2,
        MODE_GLYPH  = 3'd3,
        MODE_READ   = 3'd4
    } mode_t;

    typedef enum logic [1:0] {
        ST_DONE    = 2'd0,
        ST_BADCODE = 2'd1,
        ST_OVERRUN = 2'd2
    } status_t;

    typedef enum logic [0:0] {
        CFG_GW = 1'b0,
        CFG_GH = 1'b1
    } cfg_idx_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FILL,
        S_RD,
        S_WAIT,
        S_MOD,
        S_WR,
        S_DONE
    } state_t;

endpackage
`default_nettype wire

// ----- rtl/mono_page_framebuffer_text_draw_unit.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mono_page_framebuffer_text_draw_unit
// 1-bit page framebuffer with text cursor and glyph row painting
// ----------------------------------------------------------------------------
// channel   | signals                                        | direction
// command   | start/busy, mode..advance                      | in
// result    | done, status, read_byte, cursor_x, cursor_y    | out
// config    | cfg_we, cfg_index, cfg_data                    | in
// after reset a clearing pass over all W*H/8 bytes (1024 by default) holds busy
// fill: one byte per cycle over the whole store; glyph row: per column byte a
// sequence, read, wait and write step; pixel: read, wait, write; read byte:
// read, wait; set cursor, unused modes and rejected glyph rows: no store access
// column lanes compute pixel and enable for all columns, the sequencer
// merges them into the store one byte at a time through the single ram port
// the receiver cannot stall; done lasts one cycle
// ----------------------------------------------------------------------------
module mono_page_framebuffer_text_draw_unit #(
    parameter int SCREEN_WIDTH   = mpfb_pkg::SCREEN_WIDTH_DEF,
    parameter int SCREEN_HEIGHT  = mpfb_pkg::SCREEN_HEIGHT_DEF,
    parameter int MAX_GLYPH_COLS = mpfb_pkg::MAX_GLYPH_COLS_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [2:0]  mode,
    input  wire logic [7:0]  pos_x,
    input  wire logic [7:0]  pos_y,
    input  wire logic        color,
    input  wire logic [7:0]  char_code,
    input  wire logic [15:0] row_bits,
    input  wire logic [4:0]  row_index,
    input  wire logic        last_row,
    input  wire logic [4:0]  advance,
    input  wire logic        cfg_we,
    input  wire logic        cfg_index,
    input  wire logic [5:0]  cfg_data,
    output logic             done,
    output logic [1:0]       status,
    output logic [7:0]       read_byte,
    output logic [7:0]       cursor_x,
    output logic [7:0]       cursor_y
);

    localparam int PAGES = SCREEN_HEIGHT / 8;
    localparam int DEPTH = SCREEN_WIDTH * PAGES;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(MAX_GLYPH_COLS + 1);
    localparam int LW    = (MAX_GLYPH_COLS > 1) ? $clog2(MAX_GLYPH_COLS) : 1;

    mpfb_pkg::state_t state_reg, state_next;

    logic [4:0]  gw_reg;
    logic [5:0]  gh_reg;
    logic [7:0]  col_reg, col_next;
    logic [7:0]  row_reg, row_next;
    logic [AW:0] cnt_reg, cnt_next;
    logic [CW-1:0] lane_reg, lane_next;
    logic        fillv_reg, fillv_next;
    logic        clr_reg, clr_next;
    logic        ram_we;
    logic [AW-1:0] ram_addr;
    logic [7:0]  ram_wdata, ram_rdata;
    logic        done_next;
    logic [1:0]  status_next;
    logic [7:0]  rb_next;

    // latched command
    logic [2:0]  m_reg;
    logic [7:0]  px_reg, py_reg, cc_reg;
    logic        c_reg, last_reg;
    logic [15:0] bits_reg;
    logic [4:0]  ri_reg, adv_reg;
    logic [7:0]  byte_reg, byte_next;

    logic [4:0]  used_w;
    logic [MAX_GLYPH_COLS-1:0] lane_en, lane_pix;
    logic [8:0]  gy;
    logic [8:0]  rx_sum;
    logic [8:0]  ry_sum;

    assign used_w = (gw_reg > 5'(MAX_GLYPH_COLS)) ? 5'(MAX_GLYPH_COLS) : gw_reg;
    assign gy     = {1'b0, row_reg} + {4'b0, ri_reg};
    assign rx_sum = {1'b0, col_reg} + {4'b0, used_w};
    assign ry_sum = {1'b0, row_reg} + {3'b0, gh_reg};

    genvar g;
    generate
        for (g = 0; g < MAX_GLYPH_COLS; g++)
        begin : g_lane
            mpfb_lane #(
                .LANE(g),
                .SCREEN_WIDTH(SCREEN_WIDTH)
            ) u_lane (
                .row_bits(bits_reg),
                .used_w(used_w),
                .col(col_reg),
                .color(c_reg),
                .en(lane_en[g]),
                .pix(lane_pix[g])
            );
        end
    endgenerate

    mpfb_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_ram (
        .clk(clk),
        .we(ram_we),
        .addr(ram_addr),
        .wdata(ram_wdata),
        .rdata(ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mpfb_pkg::S_FILL;
            gw_reg    <= 5'(mpfb_pkg::GW_RESET);
            gh_reg    <= 6'(mpfb_pkg::GH_RESET);
            col_reg   <= '0;
            row_reg   <= '0;
            cnt_reg   <= '0;
            lane_reg  <= '0;
            fillv_reg <= 1'b0;
            clr_reg   <= 1'b1;
            done      <= 1'b0;
            status    <= '0;
            read_byte <= '0;
        end
        else
        begin
            state_reg <= state_next;
            col_reg   <= col_next;
            row_reg   <= row_next;
            cnt_reg   <= cnt_next;
            lane_reg  <= lane_next;
            fillv_reg <= fillv_next;
            clr_reg   <= clr_next;
            done      <= done_next;
            status    <= status_next;
            read_byte <= rb_next;
            if (cfg_we)
            begin
                unique case (mpfb_pkg::cfg_idx_t'(cfg_index))
                    mpfb_pkg::CFG_GW: gw_reg <= cfg_data[4:0];
                    mpfb_pkg::CFG_GH: gh_reg <= cfg_data;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
        if (start && !busy)
        begin
            m_reg    <= mode;
            px_reg   <= pos_x;
            py_reg   <= pos_y;
            c_reg    <= color;
            cc_reg   <= char_code;
            bits_reg <= row_bits;
            ri_reg   <= row_index;
            last_reg <= last_row;
            adv_reg  <= advance;
        end
    end

    assign busy     = (state_reg != mpfb_pkg::S_IDLE);
    assign cursor_x = col_reg;
    assign cursor_y = row_reg;

    always_comb
    begin
        state_next  = state_reg;
        col_next    = col_reg;
        row_next    = row_reg;
        cnt_next    = cnt_reg;
        lane_next   = lane_reg;
        fillv_next  = fillv_reg;
        clr_next    = clr_reg;
        byte_next   = byte_reg;
        done_next   = 1'b0;
        status_next = status;
        rb_next     = read_byte;
        ram_we      = 1'b0;
        ram_addr    = cnt_reg[AW-1:0];
        ram_wdata   = {8{fillv_reg}};
        unique case (state_reg)
            mpfb_pkg::S_IDLE:
            begin
                if (start)
                begin
                    lane_next = '0;
                    cnt_next  = '0;
                    unique case (mode)
                        mpfb_pkg::MODE_FILL:
                        begin
                            fillv_next = color;
                            state_next = mpfb_pkg::S_FILL;
                        end
                        mpfb_pkg::MODE_PIXEL, mpfb_pkg::MODE_READ:
                            state_next = mpfb_pkg::S_RD;
                        mpfb_pkg::MODE_GLYPH:
                            state_next = mpfb_pkg::S_MOD;
                        default:
                            state_next = mpfb_pkg::S_DONE;
                    endcase
                end
            end
            mpfb_pkg::S_FILL:
            begin
                ram_we   = 1'b1;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == (AW+1)'(DEPTH - 1))
                begin
                    // the clearing pass after reset ends without a result
                    if (clr_reg)
                    begin
                        clr_next   = 1'b0;
                        state_next = mpfb_pkg::S_IDLE;
                    end
                    else
                    begin
                        state_next = mpfb_pkg::S_DONE;
                    end
                end
            end
            mpfb_pkg::S_RD:
            begin
                // address of the byte for the current transfer
                if (m_reg == mpfb_pkg::MODE_GLYPH)
                begin
                    ram_addr = AW'(16'(col_reg) + 16'(lane_reg)
                               + 16'(gy[7:3]) * 16'(SCREEN_WIDTH));
                end
                else
                begin
                    ram_addr = AW'(16'(px_reg) + 16'(py_reg[7:3]) * 16'(SCREEN_WIDTH));
                end
                cnt_next   = (AW+1)'(ram_addr);
                state_next = mpfb_pkg::S_WAIT;
            end
            mpfb_pkg::S_WAIT:
            begin
                ram_addr   = cnt_reg[AW-1:0];
                byte_next  = ram_rdata;
                state_next = mpfb_pkg::S_WR;
                if (m_reg == mpfb_pkg::MODE_READ)
                begin
                    if ({1'b0, px_reg} < 9'(SCREEN_WIDTH)
                        && {1'b0, py_reg[7:3]} < 6'(PAGES))
                    begin
                        rb_next = ram_rdata;
                    end
                    else
                    begin
                        rb_next = '0;
                    end
                    state_next = mpfb_pkg::S_DONE;
                end
            end
            mpfb_pkg::S_WR:
            begin
                ram_addr = cnt_reg[AW-1:0];
                if (m_reg == mpfb_pkg::MODE_PIXEL)
                begin
                    ram_wdata = byte_reg;
                    ram_wdata[py_reg[2:0]] = c_reg;
                    ram_we = ({1'b0, px_reg} < 9'(SCREEN_WIDTH))
                             && ({1'b0, py_reg} < 9'(SCREEN_HEIGHT));
                    state_next = mpfb_pkg::S_DONE;
                end
                else
                begin
                    ram_wdata = byte_reg;
                    ram_wdata[gy[2:0]] = lane_pix[lane_reg[LW-1:0]];
                    ram_we    = 1'b1;
                    lane_next = lane_reg + 1'b1;
                    state_next = mpfb_pkg::S_MOD;
                end
            end
            mpfb_pkg::S_MOD:
            begin
                // glyph sequencing: checks on entry, then one lane per pass
                if (lane_reg == '0 && (cc_reg < mpfb_pkg::CODE_LO
                                       || cc_reg > mpfb_pkg::CODE_HI))
                begin
                    status_next = mpfb_pkg::ST_BADCODE;
                    rb_next     = '0;
                    state_next  = mpfb_pkg::S_IDLE;
                    done_next   = 1'b1;
                end
                else if (lane_reg == '0 && (rx_sum > 9'(SCREEN_WIDTH)
                                            || ry_sum > 9'(SCREEN_HEIGHT)))
                begin
                    status_next = mpfb_pkg::ST_OVERRUN;
                    rb_next     = '0;
                    state_next  = mpfb_pkg::S_IDLE;
                    done_next   = 1'b1;
                end
                else if (lane_reg < CW'(MAX_GLYPH_COLS)
                         && lane_en[lane_reg[LW-1:0]]
                         && gy < 9'(SCREEN_HEIGHT))
                begin
                    state_next = mpfb_pkg::S_RD;
                end
                else if (lane_reg < CW'(MAX_GLYPH_COLS) && 5'(lane_reg) < used_w)
                begin
                    lane_next = lane_reg + 1'b1;
                end
                else
                begin
                    if (last_reg)
                    begin
                        col_next = col_reg + ((adv_reg != '0) ? {3'b0, adv_reg}
                                                              : {3'b0, used_w});
                    end
                    status_next = mpfb_pkg::ST_DONE;
                    rb_next     = '0;
                    state_next  = mpfb_pkg::S_IDLE;
                    done_next   = 1'b1;
                end
            end
            mpfb_pkg::S_DONE:
            begin
                if (m_reg == mpfb_pkg::MODE_CURSOR)
                begin
                    col_next = px_reg;
                    row_next = py_reg;
                end
                status_next = mpfb_pkg::ST_DONE;
                if (m_reg != mpfb_pkg::MODE_READ)
                begin
                    rb_next = '0;
                end
                done_next  = 1'b1;
                state_next = mpfb_pkg::S_IDLE;
            end
            default:
                state_next = mpfb_pkg::S_IDLE;
        endcase
    end

endmodule
`default_nettype wire

// ----- rtl/mpfb_ram.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mpfb_ram
// generic single port ram with registered read
// ----------------------------------------------------------------------------
module mpfb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule
`default_nettype wire

// ----- rtl/mpfb_lane.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mpfb_lane
// one column lane: glyph bit for its column and its write enable, used as a lane mask
// ----------------------------------------------------------------------------
module mpfb_lane #(
    parameter int LANE = 0,
    parameter int SCREEN_WIDTH = 128
) (
    input  wire logic [15:0] row_bits,
    input  wire logic [4:0]  used_w,
    input  wire logic [7:0]  col,
    input  wire logic        color,
    output logic             en,
    output logic             pix
);

    logic [8:0] x;

    always_comb
    begin
        x   = {1'b0, col} + 9'(LANE);
        en  = (5'(LANE) < used_w) && (x < 9'(SCREEN_WIDTH));
        pix = row_bits[15-LANE] ? color : ~color;
    end

endmodule
`default_nettype wire

// ----- rtl/mpfb_checker.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mpfb_checker
// port level checks for the framebuffer text unit
// ----------------------------------------------------------------------------
module mpfb_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       start,
    input wire logic       busy,
    input wire logic       done,
    input wire logic [1:0] status,
    input wire logic [7:0] read_byte
);

    // results never come back to back
    a_done_gap: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done) else $error("back to back results");

    // status never shows the unused code
    a_status: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> status != 2'd3) else $error("bad status");

    // read data and error status are exclusive
    a_excl: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status != 2'd0) |-> read_byte == 8'd0) else $error("stray read data");

    // an accepted transfer makes the unit busy
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy) else $error("no busy after transfer");

endmodule

bind mono_page_framebuffer_text_draw_unit mpfb_checker u_mpfb_checker (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .done(done),
    .status(status),
    .read_byte(read_byte)
);
`default_nettype wire

// ----- sim/tb_mono_page_framebuffer_text_draw_unit.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tb_mono_page_framebuffer_text_draw_unit
// drives commands into the page framebuffer text unit and checks every result
// against a behavioural model of the store, the cursor and the glyph painting
// ----------------------------------------------------------------------------
module tb_mono_page_framebuffer_text_draw_unit;

    localparam int SW = mpfb_pkg::SCREEN_WIDTH_DEF;
    localparam int SH = mpfb_pkg::SCREEN_HEIGHT_DEF;
    localparam int STORE_BYTES = SW * (SH / 8);
    localparam int CYCLE_LIMIT = 2000000;

    typedef struct packed {
        logic [1:0] status;
        logic [7:0] read_byte;
        logic [7:0] cursor_x;
        logic [7:0] cursor_y;
    } draw_result_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [2:0]  mode;
    logic [7:0]  pos_x;
    logic [7:0]  pos_y;
    logic        color;
    logic [7:0]  char_code;
    logic [15:0] row_bits;
    logic [4:0]  row_index;
    logic        last_row;
    logic [4:0]  advance;
    logic        cfg_we;
    logic        cfg_index;
    logic [5:0]  cfg_data;
    logic        done;
    logic [1:0]  status;
    logic [7:0]  read_byte;
    logic [7:0]  cursor_x;
    logic [7:0]  cursor_y;

    logic [7:0]   page_mem [STORE_BYTES];
    logic [7:0]   mdl_col;
    logic [7:0]   mdl_row;
    logic [4:0]   mdl_gw;
    logic [5:0]   mdl_gh;
    draw_result_t pending_results[$];
    int           fail_count;
    int           cycle_count;
    int           burst_left;

    mono_page_framebuffer_text_draw_unit i_dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .mode(mode),
        .pos_x(pos_x), .pos_y(pos_y), .color(color), .char_code(char_code),
        .row_bits(row_bits), .row_index(row_index), .last_row(last_row),
        .advance(advance), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .done(done), .status(status),
        .read_byte(read_byte), .cursor_x(cursor_x), .cursor_y(cursor_y)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    function automatic void plot(int x, int y, logic white);
        int idx;
        if (x >= SW || y >= SH)
            return;
        idx = x + (y / 8) * SW;
        page_mem[idx][y % 8] = white;
    endfunction

    // predicted outcome of one command, updating the model state
    function automatic draw_result_t predict_draw(logic [2:0] m, logic [7:0] x,
        logic [7:0] y, logic c, logic [7:0] code, logic [15:0] bits,
        logic [4:0] ridx, logic lst, logic [4:0] adv);
        draw_result_t r;
        int w;
        r = '0;
        w = (int'(mdl_gw) > mpfb_pkg::MAX_GLYPH_COLS_DEF) ? mpfb_pkg::MAX_GLYPH_COLS_DEF
                                                         : int'(mdl_gw);
        case (m)
            mpfb_pkg::MODE_FILL:
                for (int i = 0; i < STORE_BYTES; i++)
                    page_mem[i] = c ? 8'hFF : 8'h00;
            mpfb_pkg::MODE_PIXEL:
                plot(int'(x), int'(y), c);
            mpfb_pkg::MODE_CURSOR:
            begin
                mdl_col = x;
                mdl_row = y;
            end
            mpfb_pkg::MODE_GLYPH:
                if (code < mpfb_pkg::CODE_LO || code > mpfb_pkg::CODE_HI)
                    r.status = mpfb_pkg::ST_BADCODE;
                else if (SW < int'(mdl_col) + w || SH < int'(mdl_row) + int'(mdl_gh))
                    r.status = mpfb_pkg::ST_OVERRUN;
                else
                begin
                    for (int j = 0; j < w; j++)
                        plot(int'(mdl_col) + j, int'(mdl_row) + int'(ridx),
                             bits[15 - j] ? c : ~c);
                    if (lst)
                        mdl_col = mdl_col + ((adv != 0) ? {3'b0, adv} : w[7:0]);
                end
            mpfb_pkg::MODE_READ:
                if (int'(x) < SW && (int'(y) / 8) < SH / 8)
                    r.read_byte = page_mem[int'(x) + (int'(y) / 8) * SW];
            default: ;
        endcase
        r.cursor_x = mdl_col;
        r.cursor_y = mdl_row;
        return r;
    endfunction

    // result checker; done is sampled at the edge that ends its cycle
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result transfer with nothing expected");
                fail_count++;
            end
            else
            begin
                draw_result_t e;
                e = pending_results.pop_front();
                if (status !== e.status)
                begin
                    $error("status expected %0d actual %0d", e.status, status);
                    fail_count++;
                end
                if (read_byte !== e.read_byte)
                begin
                    $error("read_byte expected %0h actual %0h", e.read_byte, read_byte);
                    fail_count++;
                end
                if (cursor_x !== e.cursor_x)
                begin
                    $error("cursor_x expected %0d actual %0d", e.cursor_x, cursor_x);
                    fail_count++;
                end
                if (cursor_y !== e.cursor_y)
                begin
                    $error("cursor_y expected %0d actual %0d", e.cursor_y, cursor_y);
                    fail_count++;
                end
            end
        end
    end

    // start stays high through a burst; it drops only at a gap or a drain
    task automatic send_cmd(logic [2:0] m, logic [7:0] x, logic [7:0] y, logic c,
        logic [7:0] code, logic [15:0] bits, logic [4:0] ridx, logic lst,
        logic [4:0] adv);
        // bursty sender: random gaps between bursts
        if (burst_left == 0)
        begin
            burst_left = int'($urandom_range(1, 12));
            if ($urandom_range(0, 2) == 0)
            begin
                start <= 1'b0;
                repeat ($urandom_range(1, 20)) @(posedge clk);
            end
        end
        burst_left--;
        start <= 1'b1;
        mode <= m;
        pos_x <= x;
        pos_y <= y;
        color <= c;
        char_code <= code;
        row_bits <= bits;
        row_index <= ridx;
        last_row <= lst;
        advance <= adv;
        do
            @(posedge clk);
        while (busy);
        pending_results.push_back(predict_draw(m, x, y, c, code, bits, ridx, lst, adv));
    endtask

    task automatic drain_results();
        start <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_reg(mpfb_pkg::cfg_idx_t idx, logic [5:0] val);
        drain_results();
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == mpfb_pkg::CFG_GW)
            mdl_gw = val[4:0];
        else
            mdl_gh = val;
    endtask

    task automatic send_glyph(logic [7:0] code, logic c, logic [15:0] bits,
        logic [4:0] ridx, logic lst, logic [4:0] adv);
        send_cmd(mpfb_pkg::MODE_GLYPH, 8'($urandom), 8'($urandom), c, code, bits,
                 ridx, lst, adv);
    endtask

    task automatic read_cmd(logic [7:0] x, logic [7:0] y);
        send_cmd(mpfb_pkg::MODE_READ, x, y, 1'($urandom), 8'($urandom), 16'($urandom),
                 5'($urandom), 1'($urandom), 5'($urandom));
    endtask

    task automatic test_directed();
        send_cmd(mpfb_pkg::MODE_FILL, 0, 0, 1'b1, 0, 0, 0, 0, 0);
        read_cmd(8'd127, 8'd63);
        send_cmd(mpfb_pkg::MODE_FILL, 0, 0, 1'b0, 0, 0, 0, 0, 0);
        send_cmd(mpfb_pkg::MODE_PIXEL, 8'd127, 8'd63, 1'b1, 0, 0, 0, 0, 0);
        send_cmd(mpfb_pkg::MODE_PIXEL, 8'd255, 8'd255, 1'b1, 0, 0, 0, 0, 0);
        read_cmd(8'd127, 8'd63);
        read_cmd(8'd128, 8'd0);
        read_cmd(8'd0, 8'd64);
        send_cmd(mpfb_pkg::MODE_CURSOR, 8'd10, 8'd3, 0, 0, 0, 0, 0, 0);
        send_glyph(8'd31, 1'b1, 16'hFFFF, 0, 1, 0);
        send_glyph(8'd127, 1'b1, 16'hFFFF, 0, 1, 0);
        send_glyph(8'd32, 1'b1, 16'hA5A5, 0, 0, 0);
        send_glyph(8'd126, 1'b0, 16'h0000, 31, 1, 0);
        send_glyph(8'd65, 1'b1, 16'h8001, 2, 1, 5'd16);
        read_cmd(8'd10, 8'd3);
        send_cmd(mpfb_pkg::MODE_CURSOR, 8'd122, 8'd0, 0, 0, 0, 0, 0, 0);
        send_glyph(8'd65, 1'b1, 16'hFFFF, 0, 1, 0);
        send_cmd(mpfb_pkg::MODE_CURSOR, 8'd0, 8'd55, 0, 0, 0, 0, 0, 0);
        send_glyph(8'd65, 1'b1, 16'hFFFF, 0, 1, 0);
        send_cmd(3'd5, 8'hFF, 8'hFF, 1, 8'hFF, 16'hFFFF, 5'h1F, 1, 5'h1F);
        send_cmd(3'd7, 8'h00, 8'h00, 0, 8'h00, 16'h0000, 5'h00, 0, 5'h00);
        send_cmd(3'd6, 0, 0, 0, 0, 0, 0, 0, 0);
        // hold the sender until everything has come back
        drain_results();
    endtask

    task automatic test_config_extremes();
        write_reg(mpfb_pkg::CFG_GW, 6'd16);
        write_reg(mpfb_pkg::CFG_GH, 6'd32);
        send_cmd(mpfb_pkg::MODE_CURSOR, 8'd112, 8'd32, 0, 0, 0, 0, 0, 0);
        send_glyph(8'd80, 1'b1, 16'hF0F0, 5, 1, 0);
        write_reg(mpfb_pkg::CFG_GW, 6'd31);
        write_reg(mpfb_pkg::CFG_GH, 6'd63);
        send_cmd(mpfb_pkg::MODE_CURSOR, 8'd0, 8'd0, 0, 0, 0, 0, 0, 0);
        send_glyph(8'd80, 1'b1, 16'hFFFF, 0, 1, 0);
        write_reg(mpfb_pkg::CFG_GW, 6'd0);
        write_reg(mpfb_pkg::CFG_GH, 6'd1);
        send_glyph(8'd80, 1'b1, 16'hFFFF, 0, 1, 0);
        send_glyph(8'd80, 1'b1, 16'hFFFF, 0, 1, 5'd31);
        read_cmd(8'd0, 8'd0);
        write_reg(mpfb_pkg::CFG_GW, 6'd1);
        send_cmd(mpfb_pkg::MODE_CURSOR, 8'd127, 8'd63, 0, 0, 0, 0, 0, 0);
        send_glyph(8'd90, 1'b1, 16'h8000, 0, 1, 0);
        read_cmd(8'd127, 8'd63);
    endtask

    task automatic test_random_text(int n_items);
        int sent;
        logic [15:0] bits;
        sent = 0;
        while (sent < n_items)
        begin
            if ($urandom_range(0, 3) == 0)
            begin
                write_reg(mpfb_pkg::CFG_GW, 6'($urandom_range(0, 31)));
                write_reg(mpfb_pkg::CFG_GH, 6'($urandom_range(0, 63)));
            end
            // mostly well-formed glyphs placed on screen
            send_cmd(mpfb_pkg::MODE_CURSOR, 8'($urandom_range(0, 120)),
                     8'($urandom_range(0, 60)), 0, 0, 0, 0, 0, 0);
            sent++;
            for (int r = 0; r < 6; r++)
            begin
                bits = 16'($urandom);
                if ($urandom_range(0, 9) == 0)
                    send_glyph(8'($urandom), 1'($urandom), bits, 5'($urandom),
                               1'($urandom), 5'($urandom));
                else
                    send_glyph(8'($urandom_range(32, 126)), 1'($urandom), bits, 5'(r),
                               r == 5, 5'($urandom_range(0, 16)));
                sent++;
            end
            repeat (3)
            begin
                case ($urandom_range(0, 9))
                    0: send_cmd(mpfb_pkg::MODE_FILL, 0, 0, 1'($urandom), 0, 0, 0, 0, 0);
                    1, 2: send_cmd(mpfb_pkg::MODE_PIXEL, 8'($urandom), 8'($urandom),
                                   1'($urandom), 8'($urandom), 16'($urandom),
                                   5'($urandom), 1'($urandom), 5'($urandom));
                    3: send_cmd(3'($urandom), 8'($urandom), 8'($urandom), 1'($urandom),
                                8'($urandom), 16'($urandom), 5'($urandom),
                                1'($urandom), 5'($urandom));
                    default: read_cmd(8'($urandom_range(0, 130)),
                                      8'($urandom_range(0, 70)));
                endcase
                sent++;
            end
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        mode = '0;
        pos_x = '0;
        pos_y = '0;
        color = '0;
        char_code = '0;
        row_bits = '0;
        row_index = '0;
        last_row = '0;
        advance = '0;
        cfg_we = 1'b0;
        cfg_index = 1'b0;
        cfg_data = '0;
        fail_count = 0;
        cycle_count = 0;
        burst_left = 0;
        for (int i = 0; i < STORE_BYTES; i++)
            page_mem[i] = 8'h00;
        mdl_col = 0;
        mdl_row = 0;
        mdl_gw = 5'(mpfb_pkg::GW_RESET);
        mdl_gh = 6'(mpfb_pkg::GH_RESET);
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        test_directed();
        test_config_extremes();
        test_random_text(380);
        drain_results();
        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule
`default_nettype wire
